// ----- hdl/ntcadc_pkg.sv -----
// Shared constants, breakpoint tables and types for the NTC ADC to temperature block.
`timescale 1ns / 1ps

package ntcadc_pkg;

    localparam int TABLE_ENTRIES  = 30;
    localparam int STORED_ENTRIES = 30;
    localparam int IDX_W          = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SIDX_W         = $clog2(STORED_ENTRIES);

    localparam int ADC_W   = 12;
    localparam int SPAN_W  = 8;
    localparam int BPT_W   = 12;
    localparam int PROD_W  = 18;
    localparam int TEMP_W  = 20;
    localparam int OUT_W   = 16;
    localparam int OFS_W   = 8;

    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [PROD_W-1:0] SLOPE_TENTHS = PROD_W'(50);
    localparam logic signed [TEMP_W-1:0] TEMP_HIGH_LIMIT = TEMP_W'(999);
    localparam logic signed [TEMP_W-1:0] TEMP_LOW_LIMIT  = -TEMP_W'(400);
    localparam logic [OFS_W-1:0] OFFSET_RESET = '0;
    localparam logic [OUT_W-1:0] ALARM_RESET  = OUT_W'(32767);

    localparam logic [ADC_W-1:0] BP_COUNT [STORED_ENTRIES] = '{
        12'd3976, 12'd3932, 12'd3876, 12'd3800, 12'd3712, 12'd3600, 12'd3468, 12'd3312,
        12'd3132, 12'd2936, 12'd2724, 12'd2504, 12'd2276, 12'd2048, 12'd1824, 12'd1620,
        12'd1424, 12'd1244, 12'd1088, 12'd944,  12'd816,  12'd704,  12'd612,  12'd528,
        12'd456,  12'd396,  12'd344,  12'd300,  12'd260,  12'd0
    };

    localparam logic signed [BPT_W-1:0] BP_TEMP [STORED_ENTRIES] = '{
        -12'sd400, -12'sd350, -12'sd300, -12'sd250, -12'sd200, -12'sd150, -12'sd100,
        -12'sd50,  12'sd0,    12'sd50,   12'sd100,  12'sd150,  12'sd200,  12'sd250,
        12'sd300,  12'sd350,  12'sd400,  12'sd450,  12'sd500,  12'sd550,  12'sd600,
        12'sd650,  12'sd700,  12'sd750,  12'sd800,  12'sd850,  12'sd900,  12'sd950,
        12'sd1000, 12'sd2000
    };

    localparam logic [SPAN_W-1:0] BP_SPAN [STORED_ENTRIES] = '{
        8'd36,  8'd44,  8'd56,  8'd76,  8'd88,  8'd112, 8'd132, 8'd156, 8'd180, 8'd196,
        8'd212, 8'd220, 8'd228, 8'd228, 8'd224, 8'd204, 8'd196, 8'd180, 8'd156, 8'd128,
        8'd128, 8'd112, 8'd92,  8'd84,  8'd72,  8'd60,  8'd52,  8'd44,  8'd40,  8'd255
    };

    typedef enum logic [0:0] {
        REG_OFFSET = 1'b0,
        REG_ALARM  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic logic [SIDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] i);
        logic [SIDX_W-1:0] j;
        j = (int'(i) < STORED_ENTRIES) ? SIDX_W'(i) : SIDX_W'(STORED_ENTRIES - 1);
        return j;
    endfunction

    function automatic logic [ADC_W-1:0] bp_count(input logic [IDX_W-1:0] i);
        return BP_COUNT[clamp_idx(i)];
    endfunction

    function automatic logic signed [BPT_W-1:0] bp_temp(input logic [IDX_W-1:0] i);
        return BP_TEMP[clamp_idx(i)];
    endfunction

    function automatic logic [SPAN_W-1:0] bp_span(input logic [IDX_W-1:0] i);
        logic [SPAN_W-1:0] s;
        s = BP_SPAN[clamp_idx(i)];
        return (s == '0) ? SPAN_W'(1) : s;
    endfunction

endpackage

// ----- hdl/ntcadc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module ntcadc_div
    import ntcadc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [PROD_W-1:0]   dividend,
    input  logic [SPAN_W-1:0]   divisor,
    output logic [PROD_W-1:0]   quotient,
    output div_status_t         status
);

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [PROD_W-1:0] dvd_reg, dvd_next;
    logic [SPAN_W-1:0] dsr_reg, dsr_next;
    logic [SPAN_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [SPAN_W:0]   trial;
    logic              fits;

    assign trial = {rem_reg, dvd_reg[PROD_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            cnt_next  = CNT_W'(PROD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? SPAN_W'(trial - {1'b0, dsr_reg}) : trial[SPAN_W-1:0];
            dvd_next = {dvd_reg[PROD_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient    = dvd_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ----- hdl/ntc_adc_to_temperature.sv -----
// Top level: NTC thermistor ADC count to temperature in tenths of a degree.
//
// Input beats on s_t*: s_tdata[11:0] is the ADC count. One result beat per
// input on m_t*: m_tdata is the signed temperature in tenths of a degree,
// m_tuser is set when the value was replaced by the alarm register.
// An APB port writes the offset (address 0) and the alarm value (address 4).
// Operation: a linear search over the breakpoint table, one entry per cycle,
// then a restoring divider at one quotient bit per cycle, then a final
// state for offset, range check and alarm substitution.
// The search stops at the matching table entry, 0 to 29 with the default table.
// s_tready is high only while the sequencer is idle; one item at a time.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver still stalls when the next result is ready, the
// sequencer holds that result internally until the output register frees.
// Reset (synchronous, aresetn low) clears the sequencer and m_tvalid and
// restores offset 0 and alarm value 32767. No clearing pass is needed.
`timescale 1ns / 1ps

module ntc_adc_to_temperature
    import ntcadc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] adc_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] temperature_tenths
    output logic        m_tuser,   // [0] out_of_range
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DIV,
        S_CALC
    } state_t;

    state_t                   state_reg;
    logic [ADC_W-1:0]         adc_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic signed [BPT_W-1:0]  temp_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [SPAN_W-1:0]        span_reg;
    logic                     div_start_reg;
    logic                     m_tvalid_reg;
    logic [OUT_W-1:0]         m_tdata_reg;
    logic                     m_tuser_reg;
    logic [OFS_W-1:0]         offset_reg;
    logic [OUT_W-1:0]         alarm_reg;

    logic [ADC_W-1:0]         cur_bp;
    logic                     hit;
    logic [ADC_W-1:0]         rest;
    logic [PROD_W-1:0]        quotient;
    div_status_t              div_status;
    logic signed [TEMP_W-1:0] t_val;
    logic                     alarm;
    logic                     out_free;
    logic                     cfg_wr;
    reg_idx_t                 cfg_idx;

    assign cur_bp = bp_count(idx_reg);
    assign hit    = (adc_reg >= cur_bp) || (idx_reg == LAST_IDX);
    assign rest   = (adc_reg >= cur_bp) ? (adc_reg - cur_bp) : '0;

    assign t_val = TEMP_W'(temp_reg) - $signed({2'b00, quotient})
                 + TEMP_W'($signed(offset_reg));
    assign alarm = (t_val > TEMP_HIGH_LIMIT) || (t_val < TEMP_LOW_LIMIT);
    assign out_free = !m_tvalid_reg || m_tready;

    ntcadc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (prod_reg),
        .divisor  (span_reg),
        .quotient (quotient),
        .status   (div_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            div_start_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            div_start_reg <= (state_reg == S_SEARCH) && hit;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        adc_reg   <= s_tdata[ADC_W-1:0];
                        idx_reg   <= '0;
                        state_reg <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (hit) begin
                        temp_reg  <= bp_temp(idx_reg);
                        span_reg  <= bp_span(idx_reg);
                        prod_reg  <= PROD_W'(rest) * SLOPE_TENTHS;
                        state_reg <= S_DIV;
                    end else begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                S_DIV: begin
                    if (div_status.done) begin
                        state_reg <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase

            if (state_reg == S_CALC && out_free) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= alarm ? alarm_reg : t_val[OUT_W-1:0];
                m_tuser_reg  <= alarm;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // APB registers
    assign cfg_idx = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= OFFSET_RESET;
            alarm_reg  <= ALARM_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_OFFSET: offset_reg <= pwdata[OFS_W-1:0];
                REG_ALARM:  alarm_reg  <= pwdata[OUT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_OFFSET: prdata = {{(32-OFS_W){offset_reg[OFS_W-1]}}, offset_reg};
            REG_ALARM:  prdata = {{(32-OUT_W){alarm_reg[OUT_W-1]}}, alarm_reg};
            default:    prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- hdl/ntcadc_chk.sv -----
// Port-level checker for the NTC ADC to temperature block, with its bind.
`timescale 1ns / 1ps

module ntcadc_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> ($signed(m_tdata) <= 16'sd999)
                              && ($signed(m_tdata) >= -16'sd400))
        else $error("in-range flag on out-of-range temperature");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted back to back");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind ntc_adc_to_temperature ntcadc_chk u_ntcadc_chk (.*);
